// ===== src/canny_non_max_suppression_unit_assert.svh =====
// Assertion macros shared by the non-max suppression unit RTL
`ifndef CANNY_NON_MAX_SUPPRESSION_UNIT_ASSERT_SVH
`define CANNY_NON_MAX_SUPPRESSION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, masked while rst_n is low
`define CNMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnms assertion failed");
// next-cycle implication
`define CNMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnms assertion failed");
`else
`define CNMS_ASSERT_IMP(lbl, ante, cons)
`define CNMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/cnms_pkg.sv =====
// Types and constants of the Canny non-max suppression unit
package cnms_pkg;

  localparam int GRAD_W      = 11;
  localparam int MAG_W       = 11;
  localparam int SEC_W       = 3;
  localparam int CFG_W_W     = 11;
  localparam int CFG_H_W     = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int ROW_W       = 12;

  localparam int WID_MIN       = 3;
  localparam int WID_RESET     = 640;
  localparam int WID_FIELD_MAX = (1 << CFG_W_W) - 1;
  localparam int HGT_MIN       = 3;
  localparam int HGT_MAX       = 4096;
  localparam int HGT_RESET     = 480;

  // beat kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // gradient sectors
  localparam logic [SEC_W-1:0] SEC_ZERO    = 3'd0;
  localparam logic [SEC_W-1:0] SEC_HORZ    = 3'd1;
  localparam logic [SEC_W-1:0] SEC_DIAG45  = 3'd2;
  localparam logic [SEC_W-1:0] SEC_VERT    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_DIAG135 = 3'd4;

  localparam logic [MAG_W-1:0] MAG_MAX = 11'd2047;

  // tan(22.5) and tan(67.5) in 16-bit fraction
  localparam int          TAN_FRAC = 16;
  localparam int          TAN_HI_W = 18;
  localparam logic [14:0] TAN_LO   = 15'd27146;
  localparam logic [17:0] TAN_HI   = 18'd158218;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [MAG_W-1:0] mag;
  } entry_t;

  // one line store word: newest and previous pixel of one column
  typedef struct packed {
    entry_t newer;
    entry_t older;
  } line_word_t;

  typedef struct packed {
    entry_t top;
    entry_t mid;
    entry_t bot;
  } column_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [SEC_W-1:0] sec;
    logic             eof;
  } result_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 full;
  } fifo_stat_t;

endpackage

// ===== src/cnms_if.sv =====
// Valid/ready stream interfaces for gradient input and suppressed output
interface cnms_in_if;
  import cnms_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  modport source (output valid, kind, grad_x, grad_y, input ready);
  modport sink (input valid, kind, grad_x, grad_y, output ready);
endinterface

interface cnms_out_if;
  import cnms_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] out_magnitude;
  logic [SEC_W-1:0] out_sector;
  logic             end_of_frame;
  modport source (output valid, out_magnitude, out_sector, end_of_frame, input ready);
  modport sink (input valid, out_magnitude, out_sector, end_of_frame, output ready);
endinterface

// ===== src/cnms_line_mem.sv =====
// Two-row line store: one synchronous read port and one write port
module cnms_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output cnms_pkg::line_word_t       rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  cnms_pkg::line_word_t       wr_data
);
  import cnms_pkg::*;

  line_word_t mem [DEPTH];
  line_word_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cnms_grad_sort.sv =====
// Gradient magnitude and direction sector from one Sobel pair
module cnms_grad_sort (
  input  logic signed [cnms_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [cnms_pkg::GRAD_W-1:0] grad_y,
  output cnms_pkg::entry_t                   entry
);
  import cnms_pkg::*;

  localparam int PROD_W = GRAD_W + TAN_HI_W;

  logic              neg_x, neg_y;
  logic [GRAD_W-1:0] abs_x, abs_y;
  logic [GRAD_W:0]   mag_sum;
  logic [PROD_W-1:0] ay_scaled, lo_prod, hi_prod;

  always_comb begin
    neg_x = grad_x[GRAD_W-1];
    neg_y = grad_y[GRAD_W-1];
    // -1024 maps to 1024, which still fits unsigned
    abs_x = neg_x ? GRAD_W'(~grad_x + 1'b1) : GRAD_W'(grad_x);
    abs_y = neg_y ? GRAD_W'(~grad_y + 1'b1) : GRAD_W'(grad_y);

    // L1 magnitude, saturated
    mag_sum   = (GRAD_W+1)'(abs_x) + (GRAD_W+1)'(abs_y);
    entry.mag = (mag_sum > (GRAD_W+1)'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];

    // |gy| against |gx|*tan in fixed point
    ay_scaled = PROD_W'({abs_y, {TAN_FRAC{1'b0}}});
    lo_prod   = PROD_W'(abs_x) * PROD_W'(TAN_LO);
    hi_prod   = PROD_W'(abs_x) * PROD_W'(TAN_HI);

    if (abs_x == '0 && abs_y == '0) begin
      entry.sec = SEC_ZERO;
    end else if (ay_scaled < lo_prod) begin
      entry.sec = SEC_HORZ;
    end else if (ay_scaled >= hi_prod) begin
      entry.sec = SEC_VERT;
    end else if (abs_x != '0 && abs_y != '0 && neg_x != neg_y) begin
      entry.sec = SEC_DIAG135;
    end else begin
      entry.sec = SEC_DIAG45;
    end
  end

endmodule

// ===== src/cnms_out_fifo.sv =====
// Four-entry result queue driving the output stream
module cnms_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cnms_pkg::result_t      push_data,
  output cnms_pkg::fifo_stat_t   stat,
  cnms_out_if.source             out_ch
);
  import cnms_pkg::*;

  result_t              slots [OUT_DEPTH];
  result_t              head;
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] count_r, count_nxt;
  logic                 pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  assign head                 = slots[rd_ptr_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.out_magnitude = head.mag;
  assign out_ch.out_sector    = head.sec;
  assign out_ch.end_of_frame  = head.eof;

  assign stat.count = count_r;
  assign stat.full  = (count_r == OUT_CNT_W'(OUT_DEPTH));

endmodule

// ===== src/canny_non_max_suppression_unit.sv =====
// Top level of the Canny non-maximum suppression unit.
// A result passes the read-return stage and the output queue before it is on out_ch.
// Throughput: one beat per cycle, pixel or flush, while the output queue has room; a pixel
// beat reads and writes the single line store, a flush only reads it and may take a forwarded word.
// Reset (sync rst_n): stream position, pending count and queue cleared, width 640,
// height 480; the line store is not cleared, entries are written before use.
`include "canny_non_max_suppression_unit_assert.svh"
module canny_non_max_suppression_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cnms_in_if.sink                            in_ch,
  cnms_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [cnms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cnms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cnms_pkg::*;

  localparam int WMAX    = (MAX_WIDTH < WID_FIELD_MAX) ? MAX_WIDTH : WID_FIELD_MAX;
  localparam int WID_RST = (WID_RESET < WMAX) ? WID_RESET : WMAX;
  localparam int COL_W   = $clog2(WMAX);
  localparam int WID_W   = $clog2(WMAX + 1);
  localparam int PEND_W  = $clog2(WMAX + 2);
  localparam int CMP_W   = $clog2(WMAX + 1) + 2;

  // configuration and stream position
  logic [WID_W-1:0]   w_r, w_nxt;
  logic [CFG_H_W-1:0] h_r, h_nxt;
  logic [COL_W-1:0]   wcol_r, wcol_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;

  logic [CFG_W_W-1:0] wid_raw, wid_clamp;
  logic [CFG_H_W-1:0] hgt_raw, hgt_clamp;

  // accept stage
  logic               in_acc, is_pix, emit0, interior0, eof0, old0, fwd0;
  logic               ocol_last, wcol_last, orow_last;
  logic [CMP_W-1:0]   w_c, pend_c, sum_c;
  logic [COL_W-1:0]   raddr;
  entry_t             sort_entry;

  // read-return stage
  logic               s1_valid_r, s1_emit_r, s1_fwd_r;
  logic               s1_pix_r, s1_int_r, s1_eof_r, s1_old_r;
  logic [COL_W-1:0]   s1_addr_r;
  entry_t             s1_entry_r;
  line_word_t         rd_word, wr_word, fl_word, fwd_word_r;
  column_t            cur_col, win1_r, win2_r;
  entry_t             center, nb_a, nb_b;
  logic               check, keep, wr_en;
  result_t            res;
  fifo_stat_t         fifo_stat;

  // register clamps
  always_comb begin
    wid_raw = cfg_wdata[CFG_W_W-1:0];
    hgt_raw = cfg_wdata[CFG_H_W-1:0];
    if (wid_raw < CFG_W_W'(WID_MIN)) begin
      wid_clamp = CFG_W_W'(WID_MIN);
    end else if (wid_raw > CFG_W_W'(WMAX)) begin
      wid_clamp = CFG_W_W'(WMAX);
    end else begin
      wid_clamp = wid_raw;
    end
    if (hgt_raw < CFG_H_W'(HGT_MIN)) begin
      hgt_clamp = CFG_H_W'(HGT_MIN);
    end else if (hgt_raw > CFG_H_W'(HGT_MAX)) begin
      hgt_clamp = CFG_H_W'(HGT_MAX);
    end else begin
      hgt_clamp = hgt_raw;
    end
  end

  cnms_grad_sort u_sort (
    .grad_x (in_ch.grad_x),
    .grad_y (in_ch.grad_y),
    .entry  (sort_entry)
  );

  // accept-stage decode: emit decision and position of the oldest pending pixel
  always_comb begin
    in_acc    = in_ch.valid && in_ch.ready;
    is_pix    = (in_ch.kind == KIND_PIXEL);
    w_c       = CMP_W'(w_r);
    pend_c    = CMP_W'(pend_r);
    sum_c     = CMP_W'(ocol_r) + CMP_W'(pend_r);
    ocol_last = (CMP_W'(ocol_r) + 1'b1 == w_c);
    wcol_last = (CMP_W'(wcol_r) + 1'b1 == w_c);
    orow_last = (CFG_H_W'(orow_r) + 1'b1 == h_r);
    emit0     = is_pix ? (pend_c + 1'b1 >= w_c + 2'd2) : (pend_r != '0);
    interior0 = (orow_r != '0) && (CFG_H_W'(orow_r) + 1'b1 < h_r) &&
                (ocol_r != '0) && !ocol_last;
    eof0      = orow_last && ocol_last;
    old0      = (pend_c == w_c + 1'b1);
    raddr     = is_pix ? wcol_r : ocol_r;
    fwd0      = !is_pix && s1_valid_r && s1_pix_r && (ocol_r == s1_addr_r);
  end

  // next position, pending count and registers
  always_comb begin
    w_nxt    = w_r;
    h_nxt    = h_r;
    wcol_nxt = wcol_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    pend_nxt = pend_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  w_nxt = WID_W'(wid_clamp);
        REG_HEIGHT: h_nxt = hgt_clamp;
        default:    w_nxt = w_r;
      endcase
      wcol_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
      pend_nxt = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        wcol_nxt = wcol_last ? '0 : wcol_r + 1'b1;
        if (!emit0) pend_nxt = pend_r + 1'b1;
      end else if (emit0) begin
        pend_nxt = pend_r - 1'b1;
      end
      if (emit0) begin
        ocol_nxt = ocol_last ? '0 : ocol_r + 1'b1;
        if (ocol_last) orow_nxt = orow_last ? '0 : orow_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WID_W'(WID_RST);
      h_r    <= CFG_H_W'(HGT_RESET);
      wcol_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
    end else begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      wcol_r <= wcol_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      pend_r <= pend_nxt;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_emit_r  <= in_acc && emit0;
      s1_fwd_r   <= in_acc && fwd0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    s1_pix_r   <= is_pix;
    s1_addr_r  <= raddr;
    s1_entry_r <= sort_entry;
    s1_int_r   <= interior0;
    s1_eof_r   <= eof0;
    s1_old_r   <= old0;
    fwd_word_r <= wr_word;
  end

  assign wr_en = s1_valid_r && s1_pix_r;

  cnms_line_mem #(
    .DEPTH (WMAX)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (raddr),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_word)
  );

  // window columns: two registered, newest from the line store read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win2_r <= win1_r;
      win1_r <= cur_col;
    end
  end

  // suppression of the center pixel
  always_comb begin
    cur_col.top   = rd_word.older;
    cur_col.mid   = rd_word.newer;
    cur_col.bot   = s1_entry_r;
    wr_word.newer = s1_entry_r;
    wr_word.older = rd_word.newer;
    // a flush reading the column that the preceding pixel beat writes takes the forwarded word
    fl_word = s1_fwd_r ? fwd_word_r : rd_word;
    if (s1_pix_r) begin
      center = win1_r.mid;
    end else begin
      center = s1_old_r ? fl_word.older : fl_word.newer;
    end
    case (center.sec)
      SEC_HORZ: begin
        nb_a = win2_r.mid;
        nb_b = cur_col.mid;
      end
      SEC_DIAG45: begin
        nb_a = cur_col.top;
        nb_b = win2_r.bot;
      end
      SEC_VERT: begin
        nb_a = win1_r.top;
        nb_b = win1_r.bot;
      end
      SEC_DIAG135: begin
        nb_a = win2_r.top;
        nb_b = cur_col.bot;
      end
      default: begin
        nb_a = center;
        nb_b = center;
      end
    endcase
    check   = s1_pix_r && s1_int_r && (center.sec != SEC_ZERO);
    keep    = (center.mag >= nb_a.mag) && (center.mag >= nb_b.mag);
    res.mag = (check && !keep) ? '0 : center.mag;
    res.sec = center.sec;
    res.eof = s1_eof_r;
  end

  cnms_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_emit_r),
    .push_data (res),
    .stat      (fifo_stat),
    .out_ch    (out_ch)
  );

  // take a beat only if the queue has room for the one still in flight
  assign in_ch.ready = ((OUT_CNT_W+1)'(fifo_stat.count) + (OUT_CNT_W+1)'(s1_emit_r))
                       < (OUT_CNT_W+1)'(OUT_DEPTH);

  `CNMS_ASSERT_IMP(a_pend_bound, 1'b1, pend_c <= w_c + 1'b1)
  `CNMS_ASSERT_IMP(a_pos_consistent, 1'b1, (sum_c == CMP_W'(wcol_r)) || (sum_c == CMP_W'(wcol_r) + w_c) || (sum_c == CMP_W'(wcol_r) + w_c + w_c))
  `CNMS_ASSERT_IMP(a_no_overflow, s1_emit_r, !fifo_stat.full)
  `CNMS_ASSERT_IMP(a_fwd_source, s1_fwd_r, $past(s1_valid_r && s1_pix_r))
  `CNMS_ASSERT_NXT(a_cfg_clears, cfg_we, pend_r == '0)

endmodule
